[sv/md5_pkg.sv]
// Shared types, constants and round tables for the MD5 stream hasher.
`default_nettype none
package md5_pkg;

   typedef enum logic [1:0] {
      OP_ABSORB  = 2'd0,
      OP_FINISH  = 2'd1,
      OP_RESTART = 2'd2,
      OP_SPARE   = 2'd3
   } opcode_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = (512 - 64) / 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clear;       // back to reset values
      logic       write_byte;  // store wr_data at wr_addr
      logic [5:0] wr_addr;
      logic [7:0] wr_data;
      logic       count_byte;  // add 8 to the bit length
      logic       round_en;    // run one round with index round_idx
      logic [5:0] round_idx;
      logic       load_work;   // copy chain words into working registers
      logic       fold;        // add working registers into chain words
      logic       zero_block;  // clear all block bytes
   } dp_cmd_type;

   typedef struct packed {
      logic [63:0] bit_count;
   } dp_status_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[i];
   endfunction

   function automatic logic [4:0] round_shift(input logic [5:0] i);
      logic [4:0] s [16];
      s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return s[{i[5:4], i[1:0]}];
   endfunction

   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'((i[3:0] * 4'd5) + 4'd1);
         2'd2: g = 4'((i[3:0] * 4'd3) + 4'd5);
         default: g = 4'(i[3:0] * 4'd7);
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

[sv/md5_stream_if.sv]
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface md5_stream_if #(parameter int unsigned WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/md5_datapath.sv]
// MD5 datapath: block store, chaining words, one round per cycle and length counter.
`default_nettype none
module md5_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire md5_pkg::dp_cmd_type   cmd,
   output md5_pkg::dp_status_type     status,
   output logic [127:0]               digest
);
   import md5_pkg::*;

   // The block is kept as sixteen little-endian message words.
   logic [31:0] block_ff [16];
   logic [31:0] chain_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] bits_ff;
   logic [31:0] f, w, t, rot;
   logic [3:0]  g;
   logic [4:0]  sh;

   always_comb begin
      unique case (cmd.round_idx[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      g   = word_index(cmd.round_idx);
      w   = block_ff[g];
      t   = a_ff + f + w + round_k(cmd.round_idx);
      sh  = round_shift(cmd.round_idx);
      rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         chain_ff <= '{INIT_A, INIT_B, INIT_C, INIT_D};
         bits_ff  <= '0;
         for (int i = 0; i < 16; i++) block_ff[i] <= '0;
      end else begin
         if (cmd.count_byte) bits_ff <= bits_ff + 64'd8;
         if (cmd.zero_block) begin
            for (int i = 0; i < 16; i++) block_ff[i] <= '0;
         end else if (cmd.write_byte) begin
            block_ff[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
         end
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
      end
      if (cmd.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (cmd.round_en) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot;
      end
   end

   assign status.bit_count = bits_ff;
   assign digest = {chain_ff[3], chain_ff[2], chain_ff[1], chain_ff[0]};
endmodule
`default_nettype wire

[sv/md5_control.sv]
// MD5 controller: request decode, padding sequence and round sequencing.
`default_nettype none
module md5_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [7:0]            req_data_byte,
   output logic                       rsp_load,
   input  wire logic                  rsp_free,
   input  wire md5_pkg::dp_status_type status,
   output md5_pkg::dp_cmd_type        cmd
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_LEN, ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] idx_ff, idx_in;
   logic       done_ff, done_in;
   logic       fin_ff, fin_in;     // compression belongs to a finish
   logic       last_ff, last_in;   // this compression ends the message
   logic [2:0] lenb_ff, lenb_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      done_in  = done_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      lenb_in  = lenb_ff;
      cmd      = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_ABSORB: begin
                     if (!done_ff) begin
                        cmd.write_byte = 1'b1;
                        cmd.wr_addr    = fill_ff;
                        cmd.wr_data    = req_data_byte;
                        cmd.count_byte = 1'b1;
                        fill_in        = fill_ff + 6'd1;
                        if (fill_ff == 6'd63) begin
                           fin_in   = 1'b0;
                           state_in = ST_LOAD;
                        end
                     end
                  end
                  OP_FINISH: begin
                     if (done_ff) begin
                        rsp_load = 1'b1;
                     end else begin
                        cmd.write_byte = 1'b1;
                        cmd.wr_addr    = fill_ff;
                        cmd.wr_data    = PAD_BYTE;
                        fin_in         = 1'b1;
                        if (fill_ff >= 6'(LEN_POS)) begin
                           last_in  = 1'b0;
                           state_in = ST_LOAD;
                        end else begin
                           lenb_in  = '0;
                           state_in = ST_LEN;
                        end
                     end
                  end
                  OP_RESTART: begin
                     cmd.clear = 1'b1;
                     fill_in   = '0;
                     done_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LEN: begin
            // Length bytes go in one per cycle at positions 56 to 63.
            cmd.write_byte = 1'b1;
            cmd.wr_addr    = {3'b111, lenb_ff};
            cmd.wr_data    = status.bit_count[{lenb_ff, 3'b000} +: 8];
            lenb_in        = lenb_ff + 3'd1;
            if (lenb_ff == 3'd7) begin
               last_in  = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            idx_in        = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en  = 1'b1;
            cmd.round_idx = idx_ff;
            idx_in        = idx_ff + 6'd1;
            if (idx_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold       = 1'b1;
            cmd.zero_block = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (last_ff) begin
               fill_in  = '0;
               done_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               lenb_in  = '0;
               state_in = ST_LEN;
            end
         end
         ST_EMIT: begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         lenb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         lenb_ff  <= lenb_in;
      end
   end
endmodule
`default_nettype wire

[sv/md5_stream_hasher_unit.sv]
// Top level of the MD5 stream hasher: controller, datapath and result register.
// Sequence: an absorbed byte is taken in the idle state; the 64th byte of a block starts a
// compression (one load, 64 rounds in the shared round unit, one fold).
// A finish writes the pad byte and the 8 length bytes and runs one or two compressions
// before it emits; a repeated finish loads the held digest straight from the idle state.
// Throughput is set by the one-round-per-cycle unit: no byte is taken while a block compresses.
// Synchronous active-high reset restores the RFC initial words and an empty message.
`default_nettype none
module md5_stream_hasher_unit (
   input wire logic     clock,
   input wire logic     reset,
   md5_stream_if.sink   req,
   md5_stream_if.source rsp
);
   import md5_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [127:0]  digest;
   logic          rsp_load;
   logic          rsp_valid_ff;
   logic [127:0]  rsp_data_ff;
   logic          rsp_free;

   // The result register may be refilled only once it is empty or being taken.
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   md5_control u_control (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_opcode    (req.payload[9:8]),
      .req_data_byte (req.payload[7:0]),
      .rsp_load      (rsp_load),
      .rsp_free      (rsp_free),
      .status        (status),
      .cmd           (cmd)
   );

   md5_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .digest (digest)
   );

   // Output register holding the digest until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) rsp_data_ff <= digest;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // A digest is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("digest loaded over a pending one");

   // A held digest stays stable until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(rsp_data_ff))
      else $error("pending digest changed");

   // No request is taken while a compression round runs.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !req.ready)
      else $error("request accepted during compression");
endmodule
`default_nettype wire

[dv/tb_md5_stream_hasher_unit.sv]
// Self-checking testbench for the MD5 stream hasher: directed and random requests.
`default_nettype none
module tb_md5_stream_hasher_unit;
   import md5_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A request carries the opcode above the data byte; a response carries the
   // second half of the digest above the first half.
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
   } request_type;

   typedef struct packed {
      logic [63:0] digest_second_half;
      logic [63:0] digest_first_half;
   } digest_type;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   // The longest finish needs two compressions, so this covers the tail of
   // the run with room to spare.
   localparam int unsigned DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   md5_stream_if #(.WIDTH(10))  req_if ();
   md5_stream_if #(.WIDTH(128)) rsp_if ();

   md5_stream_hasher_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #4 clock = ~clock;

   // Round additive constants and rotation amounts of the MD5 compression.
   logic [31:0] sine_table [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   int unsigned rotate_table [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

   // Our own copy of the hasher state, advanced once per accepted request.
   logic [31:0] chain_state [4];
   logic [7:0]  block_buffer [64];
   logic [5:0]  fill_level;
   logic [63:0] length_bits;
   logic        digest_ready;

   digest_type  pending_digests [$];
   int unsigned requests_sent = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;

   function automatic logic [31:0] spin_word(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void clear_state();
      chain_state[0] = INIT_A;
      chain_state[1] = INIT_B;
      chain_state[2] = INIT_C;
      chain_state[3] = INIT_D;
      foreach (block_buffer[i]) block_buffer[i] = 8'h00;
      fill_level   = '0;
      length_bits  = '0;
      digest_ready = 1'b0;
   endfunction

   // One 64-round compression of the buffered block into the chaining words,
   // after which the buffer is cleared.
   function automatic void compress_buffer();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int unsigned g;
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_buffer[4*i+3], block_buffer[4*i+2], block_buffer[4*i+1], block_buffer[4*i]};
      end
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
            2: begin f = b ^ c ^ d;          g = (3*i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
         endcase
         t = a + f + w[g] + sine_table[i];
         a = d;
         d = c;
         c = b;
         b = b + spin_word(t, rotate_table[(i / 16) * 4 + (i % 4)]);
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
      foreach (block_buffer[i]) block_buffer[i] = 8'h00;
   endfunction

   // Advance the predicted state by one accepted request; a finish queues the digest.
   function automatic void predict_request(input request_type r);
      int unsigned pos;
      case (r.opcode)
         OP_ABSORB: begin
            if (!digest_ready) begin
               block_buffer[fill_level] = r.data_byte;
               fill_level  = fill_level + 6'd1;
               length_bits = length_bits + 64'd8;
               if (fill_level == 6'd0) compress_buffer();
            end
         end
         OP_FINISH: begin
            if (!digest_ready) begin
               pos = fill_level;
               block_buffer[pos] = PAD_BYTE;
               // A pad byte at the length field or beyond forces an extra block.
               if (pos >= LEN_POS) compress_buffer();
               for (int i = 0; i < 8; i++) block_buffer[LEN_POS + i] = length_bits[8*i +: 8];
               compress_buffer();
               fill_level   = '0;
               digest_ready = 1'b1;
            end
            pending_digests.push_back('{digest_first_half:  {chain_state[1], chain_state[0]},
                                        digest_second_half: {chain_state[3], chain_state[2]}});
         end
         OP_RESTART: clear_state();
         default: ;
      endcase
   endfunction

   // Drive one request, idling beforehand at the sender's rate, and return at
   // the rising edge that accepts it. Ready is looked at on the falling edge,
   // where it is stable until the accepting edge.
   task automatic send_request(input opcode_type op, input logic [7:0] data);
      request_type r;
      r.opcode    = op;
      r.data_byte = data;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      predict_request(r);
      requests_sent++;
   endtask

   task automatic stop_sending();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // The receiver stalls at its own rate; each response is checked on the
   // falling edge before the edge that takes it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(negedge clock) begin
      digest_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_digests.size() == 0) begin
            $error("digest response with nothing expected: %h", got);
            error_count++;
         end else begin
            want = pending_digests.pop_front();
            if (got.digest_first_half !== want.digest_first_half) begin
               $error("digest_first_half: expected %h, got %h",
                      want.digest_first_half, got.digest_first_half);
               error_count++;
            end
            if (got.digest_second_half !== want.digest_second_half) begin
               $error("digest_second_half: expected %h, got %h",
                      want.digest_second_half, got.digest_second_half);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d digests outstanding",
                  cycle_count, pending_digests.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Empty message, the classic three-byte message, and both extreme byte values.
   task automatic test_short_messages();
      send_request(OP_FINISH, 8'h00);
      send_request(OP_RESTART, 8'h00);
      send_request(OP_ABSORB, "a");
      send_request(OP_ABSORB, "b");
      send_request(OP_ABSORB, "c");
      send_request(OP_FINISH, 8'h00);
      send_request(OP_RESTART, 8'hff);
      send_request(OP_ABSORB, 8'h00);
      send_request(OP_ABSORB, 8'hff);
      send_request(OP_FINISH, 8'hff);
   endtask

   // A one-byte message, the spare opcode doing nothing between bytes, and a
   // restart that discards a half-built message.
   task automatic test_special_cases();
      send_request(OP_ABSORB, 8'h5a);
      send_request(OP_FINISH, 8'h00);
      send_request(OP_RESTART, 8'h00);
      send_request(OP_ABSORB, 8'h12);
      send_request(OP_SPARE, 8'hff);
      send_request(OP_ABSORB, 8'h34);
      send_request(OP_RESTART, 8'h00);
      send_request(OP_ABSORB, 8'h77);
      send_request(OP_SPARE, 8'h00);
      send_request(OP_FINISH, 8'h00);
   endtask

   // Whole messages with random content; lengths cluster round the padding
   // boundaries so that both one- and two-block finishes occur often.
   task automatic test_random_messages(input int unsigned budget);
      int unsigned boundary_lengths [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int unsigned stop_at, msg_len, roll;
      stop_at = requests_sent + budget;
      while (requests_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 35) msg_len = boundary_lengths[$urandom_range(11)];
         else if (roll < 95) msg_len = $urandom_range(0, 70);
         else msg_len = $urandom_range(129, 200);
         if ($urandom_range(99) < 92) send_request(OP_RESTART, 8'($urandom));
         for (int i = 0; i < msg_len; i++) begin
            roll = $urandom_range(199);
            if (roll == 0) send_request(OP_RESTART, 8'($urandom));
            else if (roll < 4) send_request(OP_SPARE, 8'($urandom));
            send_request(OP_ABSORB, 8'($urandom));
         end
         send_request(OP_FINISH, 8'($urandom));
         if ($urandom_range(99) < 15) send_request(OP_ABSORB, 8'($urandom));
         if ($urandom_range(99) < 20) send_request(OP_FINISH, 8'($urandom));
      end
   endtask

   initial begin
      int unsigned drain;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      clear_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 8;
      receiver_idle_pct = 65;
      test_short_messages();
      test_special_cases();
      test_random_messages(560);

      sender_idle_pct   = 65;
      receiver_idle_pct = 8;
      test_random_messages(560);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_messages(560);
      stop_sending();

      while (pending_digests.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end

      if (error_count == 0 && pending_digests.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
